### sv/rlbc_pkg.sv
// Shared types and constants for the RGB LED blink controller.
// No dependencies; imported by the core, the output buffer, the top level and the checker.
package rlbc_pkg;

  // Item kinds on the input channel
  localparam logic FuncCmd  = 1'b0;
  localparam logic FuncTick = 1'b1;

  // Ticks between toggles after reset
  localparam logic [15:0] HalfPeriodRst = 16'd500;

  // One LED write
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       running;
  } rlbc_result_t;

endpackage

### sv/rlbc_core.sv
// Command decode, brightness scaling and blink timing for the LED controller.
// Depends on rlbc_pkg for the item kinds and the result type.
module rlbc_core import rlbc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic         func_i,
  input  logic [7:0]   red_in_i,
  input  logic [7:0]   green_in_i,
  input  logic [7:0]   blue_in_i,
  input  logic [7:0]   brightness_i,
  input  logic         blink_mode_i,
  input  logic [15:0]  repeat_count_i,
  input  logic [15:0]  period_ms_i,
  output logic         push_o,
  output rlbc_result_t result_o
);

  // ch * br / 255 as a multiply and a reciprocal correction, exact for 16-bit products
  function automatic logic [7:0] scale_channel(input logic [7:0] ch, input logic [7:0] br);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = 16'(ch) * 16'(br);
    sum  = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  logic [7:0]  color_q [3];
  logic [7:0]  color_d [3];
  logic [7:0]  scaled  [3];
  logic        active_q, active_d;
  logic        lit_q, lit_d;
  logic        limited_q, limited_d;
  logic [15:0] cycles_q, cycles_d;
  logic [15:0] half_q, half_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] elapsed_inc;

  // Scale the commanded colour
  assign scaled[0]   = scale_channel(red_in_i, brightness_i);
  assign scaled[1]   = scale_channel(green_in_i, brightness_i);
  assign scaled[2]   = scale_channel(blue_in_i, brightness_i);
  // Never wraps: elapsed stays below the half period
  assign elapsed_inc = elapsed_q + 16'd1;

  // Next state and the write that this item causes
  always_comb begin
    color_d   = color_q;
    active_d  = active_q;
    lit_d     = lit_q;
    limited_d = limited_q;
    cycles_d  = cycles_q;
    half_d    = half_q;
    elapsed_d = elapsed_q;
    push_o    = 1'b0;
    result_o  = '0;
    if (accept_i) begin
      if (func_i == FuncCmd) begin
        color_d   = scaled;
        half_d    = (period_ms_i == 16'd0) ? 16'd1 : period_ms_i;
        elapsed_d = '0;
        lit_d     = 1'b0;
        if (blink_mode_i) begin
          active_d  = 1'b1;
          limited_d = (repeat_count_i != 16'd0);
          cycles_d  = repeat_count_i;
        end else begin
          active_d  = 1'b0;
          limited_d = 1'b0;
          cycles_d  = '0;
        end
        push_o           = 1'b1;
        result_o.red     = scaled[0];
        result_o.green   = scaled[1];
        result_o.blue    = scaled[2];
        result_o.running = blink_mode_i;
      end else if (active_q) begin
        if (elapsed_inc < half_q) begin
          elapsed_d = elapsed_inc;
        end else begin
          // Toggle; a dark write closes one on-off cycle
          elapsed_d        = '0;
          lit_d            = !lit_q;
          push_o           = 1'b1;
          result_o.red     = lit_q ? color_q[0] : 8'd0;
          result_o.green   = lit_q ? color_q[1] : 8'd0;
          result_o.blue    = lit_q ? color_q[2] : 8'd0;
          result_o.running = 1'b1;
          if (limited_q && !lit_q) begin
            if (cycles_q <= 16'd1) begin
              cycles_d         = '0;
              active_d         = 1'b0;
              limited_d        = 1'b0;
              lit_d            = 1'b0;
              result_o.running = 1'b0;
            end else begin
              cycles_d = cycles_q - 16'd1;
            end
          end
        end
      end
    end
  end

  // Hold the effect state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q[0] <= '0;
      color_q[1] <= '0;
      color_q[2] <= '0;
      active_q   <= 1'b0;
      lit_q      <= 1'b0;
      limited_q  <= 1'b0;
      cycles_q   <= '0;
      half_q     <= HalfPeriodRst;
      elapsed_q  <= '0;
    end else begin
      color_q    <= color_d;
      active_q   <= active_d;
      lit_q      <= lit_d;
      limited_q  <= limited_d;
      cycles_q   <= cycles_d;
      half_q     <= half_d;
      elapsed_q  <= elapsed_d;
    end
  end

endmodule

### sv/rlbc_out_buf.sv
// Two-entry output buffer: result register plus skid register, registered ready.
// Depends on rlbc_pkg for the result type.
module rlbc_out_buf import rlbc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  rlbc_result_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         ready_i,
  output rlbc_result_t data_o
);

  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  rlbc_result_t main_q, main_d;
  rlbc_result_t skid_q, skid_d;
  logic         pop;

  assign pop     = main_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  // Advance the skid entry, or place a new result
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

### sv/rgb_led_blink_controller.sv
// Channel   | Handshake             | Payload
// input     | in_valid_i/in_ready_o | func, red/green/blue_in, brightness, blink_mode,
//           |                       | repeat_count, period_ms
// output    | out_valid_o/out_ready_i | red/green/blue_out, effect_running
//
// One item per cycle while in_ready_o is high: the core scales, counts and toggles in the
// transfer cycle and its write is registered on that edge, in the skid register if stalled.
// A tick that does not end a half period gives no write.
// A skid register lets one more item in while a write waits; in_ready_o drops only
// when both output entries are full. Reset leaves no write pending and a half period of 500.
// Depends on rlbc_pkg, rlbc_core and rlbc_out_buf.
module rgb_led_blink_controller import rlbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  brightness_i,
  input  logic        blink_mode_i,
  input  logic [15:0] repeat_count_i,
  input  logic [15:0] period_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        effect_running_o
);

  logic         accept;
  logic         push;
  rlbc_result_t result;
  rlbc_result_t out_data;

  assign accept = in_valid_i && in_ready_o;

  rlbc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .func_i         (func_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .brightness_i   (brightness_i),
    .blink_mode_i   (blink_mode_i),
    .repeat_count_i (repeat_count_i),
    .period_ms_i    (period_ms_i),
    .push_o         (push),
    .result_o       (result)
  );

  rlbc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign red_out_o        = out_data.red;
  assign green_out_o      = out_data.green;
  assign blue_out_o       = out_data.blue;
  assign effect_running_o = out_data.running;

endmodule

### sv/rlbc_checker.sv
// Port-level checks for the RGB LED blink controller, bound to the top level.
// Depends on rlbc_pkg for the item kinds.
module rlbc_port_checks import rlbc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       func_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o,
  input logic       effect_running_o
);

  // Hold a stalled write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output write dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({red_out_o, green_out_o, blue_out_o,
                                             effect_running_o}))
    else $error("stalled output payload changed");

  // Input backpressure only comes from a full output buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no write pending");

  // Every command transfer yields a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FuncCmd |=> out_valid_o)
    else $error("command transfer gave no write");

endmodule

bind rgb_led_blink_controller rlbc_port_checks u_port_checks (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .func_i           (func_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .red_out_o        (red_out_o),
  .green_out_o      (green_out_o),
  .blue_out_o       (blue_out_o),
  .effect_running_o (effect_running_o)
);

### bench/rlbc_checker.sv
// Checker for the RGB LED blink controller: predicts each LED write from the input
// transfers and compares it with the output transfers. Depends on rlbc_pkg.
module rlbc_checker import rlbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        func_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  brightness_i,
  input  logic        blink_mode_i,
  input  logic [15:0] repeat_count_i,
  input  logic [15:0] period_ms_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  red_out_i,
  input  logic [7:0]  green_out_i,
  input  logic [7:0]  blue_out_i,
  input  logic        effect_running_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Predicted LED state
  logic [7:0]   color_q [3] = '{8'd0, 8'd0, 8'd0};
  logic         blinking_q    = 1'b0;
  logic         lit_next_q    = 1'b0;
  logic         limited_q     = 1'b0;
  logic [15:0]  cycles_left_q = 16'd0;
  logic [15:0]  half_period_q = HalfPeriodRst;
  logic [15:0]  elapsed_q     = 16'd0;

  rlbc_result_t led_writes_q[$];
  rlbc_result_t want;
  rlbc_result_t fresh;
  logic         wrote;
  int           fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic logic [7:0] scale_level(logic [7:0] level, logic [7:0] bright);
    logic [15:0] prod;
    prod = 16'(level) * 16'(bright);
    return 8'(prod / 16'd255);
  endfunction

  // Advance the LED model by one item; report the write it causes, if any
  task automatic step_led(input logic f, input logic [7:0] r, g, b, br, input logic bm,
                          input logic [15:0] rep, per,
                          output logic has_write, output rlbc_result_t wr);
    logic lit;
    has_write = 1'b0;
    wr        = '0;
    if (f == FuncCmd) begin
      color_q[0]    = scale_level(r, br);
      color_q[1]    = scale_level(g, br);
      color_q[2]    = scale_level(b, br);
      half_period_q = (per == 16'd0) ? 16'd1 : per;
      elapsed_q     = 16'd0;
      lit_next_q    = 1'b0;
      blinking_q    = bm;
      limited_q     = bm && (rep != 16'd0);
      cycles_left_q = bm ? rep : 16'd0;
      has_write     = 1'b1;
      wr            = '{red: color_q[0], green: color_q[1], blue: color_q[2],
                        running: blinking_q};
    end else if (blinking_q) begin
      elapsed_q = elapsed_q + 16'd1;
      if (elapsed_q >= half_period_q) begin
        elapsed_q  = 16'd0;
        lit        = lit_next_q;
        lit_next_q = !lit_next_q;
        // a dark write closes one on-off cycle
        if (limited_q && lit_next_q) begin
          if (cycles_left_q <= 16'd1) begin
            cycles_left_q = 16'd0;
            blinking_q    = 1'b0;
            limited_q     = 1'b0;
            lit_next_q    = 1'b0;
          end else begin
            cycles_left_q = cycles_left_q - 16'd1;
          end
        end
        has_write = 1'b1;
        wr        = '{red: lit ? color_q[0] : 8'd0, green: lit ? color_q[1] : 8'd0,
                      blue: lit ? color_q[2] : 8'd0, running: blinking_q};
      end
    end
  endtask

  // Compare output transfers first, then predict from the input transfer of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q       = '{8'd0, 8'd0, 8'd0};
      blinking_q    = 1'b0;
      lit_next_q    = 1'b0;
      limited_q     = 1'b0;
      cycles_left_q = 16'd0;
      half_period_q = HalfPeriodRst;
      elapsed_q     = 16'd0;
      led_writes_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (led_writes_q.size() == 0) begin
          $error("LED write with none expected: red %0d green %0d blue %0d running %0d",
                 red_out_i, green_out_i, blue_out_i, effect_running_i);
          fail_count++;
        end else begin
          want = led_writes_q.pop_front();
          if (red_out_i !== want.red) begin
            $error("red_out: expected %0d, got %0d", want.red, red_out_i);
            fail_count++;
          end
          if (green_out_i !== want.green) begin
            $error("green_out: expected %0d, got %0d", want.green, green_out_i);
            fail_count++;
          end
          if (blue_out_i !== want.blue) begin
            $error("blue_out: expected %0d, got %0d", want.blue, blue_out_i);
            fail_count++;
          end
          if (effect_running_i !== want.running) begin
            $error("effect_running: expected %0d, got %0d", want.running, effect_running_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_led(func_i, red_in_i, green_in_i, blue_in_i, brightness_i, blink_mode_i,
                 repeat_count_i, period_ms_i, wrote, fresh);
        if (wrote) led_writes_q.push_back(fresh);
      end
      pending_o <= led_writes_q.size();
    end
  end

endmodule

### bench/testbench.sv
// Top of the bench for the RGB LED blink controller: clock, reset, stimulus, receiver
// stalls and the verdict. Depends on rlbc_pkg, rgb_led_blink_controller and rlbc_checker.
module testbench;
  import rlbc_pkg::*;

  localparam int HoldCycles  = 300;
  localparam int PhaseItems  = 200;
  localparam int TickCap     = 40;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        func         = FuncCmd;
  logic [7:0]  red_in       = 8'd0;
  logic [7:0]  green_in     = 8'd0;
  logic [7:0]  blue_in      = 8'd0;
  logic [7:0]  brightness   = 8'd0;
  logic        blink_mode   = 1'b0;
  logic [15:0] repeat_count = 16'd0;
  logic [15:0] period_ms    = 16'd0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic        effect_running;

  int  send_idle_pct = 30;
  int  recv_idle_pct = 74;
  logic hold_req     = 1'b0;
  logic hold_done    = 1'b0;
  int  hold_left     = 0;
  int  fail_count;
  int  pending;

  rgb_led_blink_controller u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .red_in_i        (red_in),
    .green_in_i      (green_in),
    .blue_in_i       (blue_in),
    .brightness_i    (brightness),
    .blink_mode_i    (blink_mode),
    .repeat_count_i  (repeat_count),
    .period_ms_i     (period_ms),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .red_out_o       (red_out),
    .green_out_o     (green_out),
    .blue_out_o      (blue_out),
    .effect_running_o(effect_running)
  );

  rlbc_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .func_i          (func),
    .red_in_i        (red_in),
    .green_in_i      (green_in),
    .blue_in_i       (blue_in),
    .brightness_i    (brightness),
    .blink_mode_i    (blink_mode),
    .repeat_count_i  (repeat_count),
    .period_ms_i     (period_ms),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .red_out_i       (red_out),
    .green_out_i     (green_out),
    .blue_out_i      (blue_out),
    .effect_running_i(effect_running),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #5 clk = ~clk;

  // Drop ready at random, or for one long stretch once a hold-off is requested
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one item, idling first at random; return in the step of its transfer
  task automatic send_item(input logic f, input logic [7:0] r, g, b, br, input logic bm,
                           input logic [15:0] rep, per);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    func         <= f;
    red_in       <= r;
    green_in     <= g;
    blue_in      <= b;
    brightness   <= br;
    blink_mode   <= bm;
    repeat_count <= rep;
    period_ms    <= per;
    do @(posedge clk); while (!in_ready);
  endtask

  // Ticks carry junk in the ignored fields
  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(FuncTick, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Favor the ends of the byte range now and then
  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  initial begin
    int          counted;
    int          ticks;
    longint      span;
    longint      cycle_ticks;
    logic        bm;
    logic [15:0] rep;
    logic [15:0] per;
    int          roll;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle ticks, static extremes, finite and endless blinks, period edges
    send_ticks(1);
    send_item(FuncCmd, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 16'd0, 16'd0);
    send_item(FuncCmd, 8'hff, 8'h80, 8'h01, 8'h00, 1'b0, 16'hffff, 16'hffff);
    send_ticks(1);
    send_item(FuncCmd, 8'hff, 8'h00, 8'hff, 8'hff, 1'b1, 16'd2, 16'd0);
    send_ticks(4);
    send_item(FuncCmd, 8'h10, 8'hff, 8'h40, 8'hc0, 1'b1, 16'd1, 16'd2);
    send_ticks(4);
    send_item(FuncCmd, 8'hff, 8'hff, 8'hff, 8'hfe, 1'b1, 16'd0, 16'd1);
    send_ticks(3);
    send_item(FuncCmd, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 16'hffff, 16'hffff);
    send_ticks(2);
    send_item(FuncCmd, 8'h7f, 8'h80, 8'h81, 8'hff, 1'b1, 16'd0, 16'd3);
    send_ticks(1);
    send_item(FuncCmd, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 16'd0, 16'd3);

    // Random: a command, then a burst of ticks, in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct <= 74;
        recv_idle_pct <= 30;
      end else if (phase == 2) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_req      <= 1'b1;
      end
      counted = 0;
      while (counted < PhaseItems) begin
        bm   = ($urandom_range(99) < 80);
        rep  = ($urandom_range(9) < 7) ? 16'($urandom_range(4)) : 16'($urandom);
        roll = $urandom_range(99);
        if (roll < 60)      per = 16'($urandom_range(3));
        else if (roll < 95) per = 16'($urandom_range(12, 4));
        else                per = 16'($urandom);
        send_item(FuncCmd, pick_level(), pick_level(), pick_level(), pick_level(),
                  bm, rep, per);
        counted++;

        // Size the tick burst to the effect; ticks past its end are noise
        cycle_ticks = 2 * longint'(rep) * ((per == 16'd0) ? 1 : longint'(per));
        if (!bm)              span = 3;
        else if (rep == 16'd0) span = TickCap;
        else                  span = (cycle_ticks + 2 < TickCap) ? cycle_ticks + 2 : TickCap;
        ticks = $urandom_range(int'(span));
        send_ticks(ticks);
        if (bm) counted += (rep == 16'd0 || ticks < cycle_ticks) ? ticks : int'(cycle_ticks);
      end
    end
    in_valid <= 1'b0;

    // Drain the expected writes, then leave room for a stray one
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
sv/rlbc_pkg.sv
sv/rlbc_core.sv
sv/rlbc_out_buf.sv
sv/rgb_led_blink_controller.sv
sv/rlbc_checker.sv
bench/rlbc_checker.sv
bench/testbench.sv
